[hdl/nec_tx_pkg.sv]
// ---------------------------------------------------------------------------
// NEC IR transmitter package
// Shared widths, codes, register reset values and the result type.
// ---------------------------------------------------------------------------
package nec_tx_pkg;

  // Input opcodes. Code 3 means nothing and is ignored.
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SEND    = 2'd1,
    OP_RELEASE = 2'd2
  } opcode_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_CUSTOM_CODE  = 3'd0,
    CFG_LEADER_MARK  = 3'd1,
    CFG_LEADER_SPACE = 3'd2,
    CFG_BIT_MARK     = 3'd3,
    CFG_ZERO_SPACE   = 3'd4,
    CFG_ONE_SPACE    = 3'd5,
    CFG_FRAME_BUDGET = 3'd6,
    CFG_UNIT_TICKS   = 3'd7
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned DurW     = 10;
  localparam int unsigned TicksW   = 11;
  localparam int unsigned UnitW    = 5;
  localparam int unsigned WeightW  = 7;
  localparam int unsigned CostW    = UnitW + WeightW;
  localparam int unsigned BitIdxW  = 5;
  localparam int unsigned FrameW   = 32;

  // Register reset values.
  localparam logic [15:0]        RstCustomCode  = 16'hFE01;
  localparam logic [DurW-1:0]    RstLeaderMark  = 10'd73;
  localparam logic [DurW-1:0]    RstLeaderSpace = 10'd36;
  localparam logic [DurW-1:0]    RstBitMark     = 10'd5;
  localparam logic [DurW-1:0]    RstZeroSpace   = 10'd5;
  localparam logic [DurW-1:0]    RstOneSpace    = 10'd14;
  localparam logic [TicksW-1:0]  RstFrameBudget = 11'd751;
  localparam logic [UnitW-1:0]   RstUnitTicks   = 5'd9;

  // One result item.
  typedef struct packed {
    logic carrier_on;
    logic busy_res;
    logic frame_done;
    logic send_ignored;
  } result_t;

endpackage

[hdl/nec_tx_in_if.sv]
// ---------------------------------------------------------------------------
// NEC IR transmitter input channel
// Valid/ready channel carrying one command item.
// ---------------------------------------------------------------------------
interface nec_tx_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] key_code;

  modport source (output valid, output opcode, output key_code, input ready);
  modport sink   (input valid, input opcode, input key_code, output ready);
endinterface

[hdl/nec_tx_out_if.sv]
// ---------------------------------------------------------------------------
// NEC IR transmitter output channel
// Valid/ready channel carrying one result item.
// ---------------------------------------------------------------------------
interface nec_tx_out_if;
  logic valid;
  logic ready;
  logic carrier_on;
  logic busy_res;
  logic frame_done;
  logic send_ignored;

  modport source (output valid, output carrier_on, output busy_res,
                  output frame_done, output send_ignored, input ready);
  modport sink   (input valid, input carrier_on, input busy_res,
                  input frame_done, input send_ignored, output ready);
endinterface

[hdl/nec_ir_frame_transmitter.sv]
// ---------------------------------------------------------------------------
// NEC IR frame transmitter
// Carrier gate sequencer for one NEC frame per send command taken while no key is held.
// ---------------------------------------------------------------------------
// The block takes one command item per clock (a 125 us tick, a send with a
// key code, or a key release) while its skid register is empty, and returns
// one registered result item for each. All sequencing state is updated in
// the same cycle that the item is taken, so items may follow back to back; the
// longest path is the 5 x 7 bit multiply and subtract that gives the stop
// space. Results go through an output register backed by one skid register,
// so one further item is still taken while a result waits at the output.
module nec_ir_frame_transmitter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [nec_tx_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [nec_tx_pkg::CfgDataW-1:0] cfg_data_i,
  nec_tx_in_if.sink                       in_if,
  nec_tx_out_if.source                    out_if
);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_LEADER = 2'd1,
    PH_DATA   = 2'd2,
    PH_STOP   = 2'd3
  } phase_e;

  // Configuration registers.
  logic [15:0]                     custom_code_q;
  logic [nec_tx_pkg::DurW-1:0]     leader_mark_q, leader_space_q, bit_mark_q;
  logic [nec_tx_pkg::DurW-1:0]     zero_space_q, one_space_q;
  logic [nec_tx_pkg::TicksW-1:0]   frame_budget_q;
  logic [nec_tx_pkg::UnitW-1:0]    unit_ticks_q;

  // Sequencer state.
  phase_e                          phase_q, phase_d;
  logic                            level_q, level_d;
  logic [nec_tx_pkg::BitIdxW-1:0]  bit_idx_q, bit_idx_d;
  logic [nec_tx_pkg::FrameW-1:0]   frame_q, frame_d;
  logic [nec_tx_pkg::TicksW-1:0]   ticks_q, ticks_d;
  logic [nec_tx_pkg::WeightW-1:0]  weight_q, weight_d;
  logic                            held_q, held_d;

  // Output register and skid register.
  nec_tx_pkg::result_t             out_q, skid_q, res;
  logic                            out_valid_q, skid_valid_q;

  logic                            accept, take;
  logic                            done, ignored;
  logic [nec_tx_pkg::BitIdxW-1:0]  nxt_idx;
  logic                            cur_bit, nxt_bit;
  logic [nec_tx_pkg::CostW-1:0]    cost;
  logic [nec_tx_pkg::TicksW-1:0]   stop_space;

  assign in_if.ready = !skid_valid_q;
  assign accept      = in_if.valid && in_if.ready;
  assign take        = out_valid_q && out_if.ready;

  // Configuration write port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      custom_code_q  <= nec_tx_pkg::RstCustomCode;
      leader_mark_q  <= nec_tx_pkg::RstLeaderMark;
      leader_space_q <= nec_tx_pkg::RstLeaderSpace;
      bit_mark_q     <= nec_tx_pkg::RstBitMark;
      zero_space_q   <= nec_tx_pkg::RstZeroSpace;
      one_space_q    <= nec_tx_pkg::RstOneSpace;
      frame_budget_q <= nec_tx_pkg::RstFrameBudget;
      unit_ticks_q   <= nec_tx_pkg::RstUnitTicks;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nec_tx_pkg::CFG_CUSTOM_CODE:  custom_code_q  <= cfg_data_i;
        nec_tx_pkg::CFG_LEADER_MARK:  leader_mark_q  <= cfg_data_i[nec_tx_pkg::DurW-1:0];
        nec_tx_pkg::CFG_LEADER_SPACE: leader_space_q <= cfg_data_i[nec_tx_pkg::DurW-1:0];
        nec_tx_pkg::CFG_BIT_MARK:     bit_mark_q     <= cfg_data_i[nec_tx_pkg::DurW-1:0];
        nec_tx_pkg::CFG_ZERO_SPACE:   zero_space_q   <= cfg_data_i[nec_tx_pkg::DurW-1:0];
        nec_tx_pkg::CFG_ONE_SPACE:    one_space_q    <= cfg_data_i[nec_tx_pkg::DurW-1:0];
        nec_tx_pkg::CFG_FRAME_BUDGET: frame_budget_q <= cfg_data_i[nec_tx_pkg::TicksW-1:0];
        nec_tx_pkg::CFG_UNIT_TICKS:   unit_ticks_q   <= cfg_data_i[nec_tx_pkg::UnitW-1:0];
        default: ;
      endcase
    end
  end

  // Current bit, the bit after it, and the stop space from the charged weight.
  assign nxt_idx = bit_idx_q + 1'b1;
  assign cur_bit = frame_q[bit_idx_q];
  assign nxt_bit = frame_q[nxt_idx];
  assign cost    = unit_ticks_q * weight_q;

  always_comb begin
    if ({1'b0, cost} + 13'd1 > {2'b00, frame_budget_q}) begin
      stop_space = 11'd1;
    end else begin
      stop_space = frame_budget_q - cost[nec_tx_pkg::TicksW-1:0];
    end
  end

  // Next sequencer state for the item being taken.
  always_comb begin
    phase_d   = phase_q;
    level_d   = level_q;
    bit_idx_d = bit_idx_q;
    frame_d   = frame_q;
    ticks_d   = ticks_q;
    weight_d  = weight_q;
    held_d    = held_q;
    done      = 1'b0;
    ignored   = 1'b0;
    if (accept) begin
      case (in_if.opcode)
        nec_tx_pkg::OP_TICK: begin
          if (phase_q != PH_IDLE) begin
            if (ticks_q > 11'd1) begin
              ticks_d = ticks_q - 1'b1;
            end else if (level_q) begin
              // A mark has ended: load the space that follows it.
              level_d = 1'b0;
              case (phase_q)
                PH_LEADER: ticks_d = {1'b0, leader_space_q};
                PH_DATA:   ticks_d = cur_bit ? {1'b0, one_space_q} : {1'b0, zero_space_q};
                default:   ticks_d = stop_space;
              endcase
            end else begin
              // A space has ended: start the next mark or finish the frame.
              level_d = 1'b1;
              ticks_d = {1'b0, bit_mark_q};
              case (phase_q)
                PH_LEADER: begin
                  phase_d   = PH_DATA;
                  bit_idx_d = '0;
                  weight_d  = frame_q[0] ? 7'd2 : 7'd1;
                end
                PH_DATA: begin
                  if (bit_idx_q == 5'd31) begin
                    phase_d = PH_STOP;
                  end else begin
                    bit_idx_d = nxt_idx;
                    weight_d  = weight_q + (nxt_bit ? 7'd2 : 7'd1);
                  end
                end
                default: begin
                  phase_d = PH_IDLE;
                  level_d = 1'b0;
                  ticks_d = '0;
                  done    = 1'b1;
                end
              endcase
            end
          end
        end
        nec_tx_pkg::OP_SEND: begin
          if (held_q) begin
            ignored = 1'b1;
          end else begin
            frame_d   = {~in_if.key_code, in_if.key_code, custom_code_q};
            phase_d   = PH_LEADER;
            level_d   = 1'b1;
            held_d    = 1'b1;
            bit_idx_d = '0;
            weight_d  = '0;
            ticks_d   = {1'b0, leader_mark_q};
          end
        end
        nec_tx_pkg::OP_RELEASE: held_d = 1'b0;
        default: ;
      endcase
    end
  end

  // Result of the item, taken from the state it leaves.
  always_comb begin
    res.carrier_on   = (phase_d != PH_IDLE) && level_d;
    res.busy_res     = (phase_d != PH_IDLE);
    res.frame_done   = done;
    res.send_ignored = ignored;
  end

  // Sequencer state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      level_q   <= 1'b0;
      bit_idx_q <= '0;
      frame_q   <= '0;
      ticks_q   <= '0;
      weight_q  <= '0;
      held_q    <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      level_q   <= level_d;
      bit_idx_q <= bit_idx_d;
      frame_q   <= frame_d;
      ticks_q   <= ticks_d;
      weight_q  <= weight_d;
      held_q    <= held_d;
    end
  end

  // Output and skid valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (take) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      if (out_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // Output and skid payload.
  always_ff @(posedge clk_i) begin
    if (take && skid_valid_q) begin
      out_q <= skid_q;
    end else if (accept && (take || !out_valid_q)) begin
      out_q <= res;
    end
    if (accept && out_valid_q && !take) begin
      skid_q <= res;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.carrier_on   = out_q.carrier_on;
  assign out_if.busy_res     = out_q.busy_res;
  assign out_if.frame_done   = out_q.frame_done;
  assign out_if.send_ignored = out_q.send_ignored;

endmodule

[hdl/nec_tx_checker.sv]
// ---------------------------------------------------------------------------
// NEC IR transmitter checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
module nec_tx_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic carrier_on_i,
  input logic busy_res_i,
  input logic frame_done_i,
  input logic send_ignored_i
);

  // The carrier is only gated on while a frame is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && carrier_on_i |-> busy_res_i)
    else $error("carrier on outside a frame");

  // The end of a frame leaves the block idle with the carrier off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_done_i |-> !busy_res_i && !carrier_on_i)
    else $error("frame done while still busy");

  // A refused send and a frame end come from different commands.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(frame_done_i && send_ignored_i))
    else $error("frame done and send refused in one result");

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before transfer");

endmodule

bind nec_ir_frame_transmitter nec_tx_checker u_nec_tx_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_if.valid),
  .out_ready_i    (out_if.ready),
  .carrier_on_i   (out_if.carrier_on),
  .busy_res_i     (out_if.busy_res),
  .frame_done_i   (out_if.frame_done),
  .send_ignored_i (out_if.send_ignored)
);
